// ===== design/button_press_classifier_queue_defines.svh =====
// Assertion macros shared by the button press classifier queue RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef BUTTON_PRESS_CLASSIFIER_QUEUE_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPCQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPCQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bpcq_pkg.sv =====
`timescale 1ns / 1ps

package bpcq_pkg;

    localparam int QUEUE_DEPTH  = 128;
    localparam int BUTTON_COUNT = 8;

    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int LEVEL_W  = 8;
    localparam int BTN_W    = $clog2(BUTTON_COUNT);
    localparam int BCNT_W   = $clog2(BUTTON_COUNT + 1);
    localparam int STATE_W  = 2;
    localparam int ENTRY_W  = STATE_W + TIME_W;
    localparam int EBTN_W   = 3;
    localparam int EVT_W    = EBTN_W + 1;
    localparam int QIDX_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int QOUT_W   = 8;
    localparam int DROP_W   = 4;

    typedef logic [QCNT_W-1:0] qcnt_t;
    typedef logic [QIDX_W-1:0] qidx_t;
    typedef logic [QOUT_W-1:0] qout_t;
    typedef logic [DROP_W-1:0] drop_t;
    typedef logic [BTN_W-1:0]  bidx_t;
    typedef logic [BCNT_W-1:0] bcnt_t;
    typedef logic [TIME_W-1:0] time_t;
    typedef logic [CFG_W-1:0]  cfg_t;
    typedef logic [STATE_W-1:0] bstate_t;
    typedef logic [EBTN_W-1:0] ebtn_t;

    localparam qcnt_t QUEUE_FULL = qcnt_t'(QUEUE_DEPTH);
    localparam qidx_t QIDX_LAST  = qidx_t'(QUEUE_DEPTH - 1);
    localparam bcnt_t BCNT_END   = bcnt_t'(BUTTON_COUNT);
    localparam drop_t DROP_MAX   = '1;

    // Per-button tracking codes held in the button memory.
    localparam bstate_t ST_RELEASED = 2'd0;
    localparam bstate_t ST_PRESSED  = 2'd1;
    localparam bstate_t ST_WAITING  = 2'd2;

    // Item function codes.
    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_RELEASE = 2'd2;

    localparam cfg_t DEBOUNCE_RESET     = 16'd20;
    localparam cfg_t LONG_HOLD_RESET    = 16'd1300;
    localparam cfg_t LONG_RELEASE_RESET = 16'd1000;

endpackage

// ===== design/bpcq_item_if.sv =====
`timescale 1ns / 1ps

interface bpcq_item_if;
    logic                             valid;
    logic                             ready;
    logic                             func;
    logic [bpcq_pkg::LEVEL_W-1:0]     button_levels;
    logic [bpcq_pkg::TIME_W-1:0]      now_ms;

    modport source (output valid, func, button_levels, now_ms, input ready);
    modport sink   (input valid, func, button_levels, now_ms, output ready);
endinterface

// ===== design/bpcq_result_if.sv =====
`timescale 1ns / 1ps

interface bpcq_result_if;
    logic                             valid;
    logic                             ready;
    logic                             event_valid;
    logic [bpcq_pkg::EBTN_W-1:0]      event_button;
    logic                             event_long;
    logic [bpcq_pkg::DROP_W-1:0]      dropped_count;
    logic [bpcq_pkg::QOUT_W-1:0]      queue_count;

    modport source (output valid, event_valid, event_button, event_long, dropped_count,
                     queue_count, input ready);
    modport sink   (input valid, event_valid, event_button, event_long, dropped_count,
                     queue_count, output ready);
endinterface

// ===== design/bpcq_cfg_if.sv =====
`timescale 1ns / 1ps

interface bpcq_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bpcq_pkg::CFG_IDX_W-1:0]   index;
    logic [bpcq_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/button_press_classifier_queue.sv =====
// Flow: a scan transaction makes one button memory access per button, 8 buttons, plus
// fill and wrap-up, before its result is ready; a pop reads the head of the event queue.
// Items: one item at a time; a new item is accepted once the previous result has
// been moved into the output register, which waits while the output holds an unaccepted result.
// Reset: asynchronous, active low; button tracking reads as released with time zero,
// the event queue is empty and the thresholds return to 20, 1300 and 1000 ms.
`timescale 1ns / 1ps
`include "button_press_classifier_queue_defines.svh"

module button_press_classifier_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    bpcq_item_if.sink            item,
    bpcq_result_if.source        result,
    bpcq_cfg_if.sink             cfg
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_POP  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    bpcq_pkg::cfg_t       debounce_reg, long_hold_reg, long_release_reg;
    bpcq_pkg::bcnt_t      scan_cnt_reg, scan_cnt_next;
    logic                 proc_valid_reg, proc_valid_next;
    bpcq_pkg::bidx_t      proc_idx_reg, proc_idx_next;
    logic [bpcq_pkg::LEVEL_W-1:0] levels_reg, levels_next;
    bpcq_pkg::time_t      now_reg, now_next;
    logic [bpcq_pkg::BUTTON_COUNT-1:0] init_reg, init_next;
    bpcq_pkg::qidx_t      wr_idx_reg, wr_idx_next;
    bpcq_pkg::qidx_t      rd_idx_reg, rd_idx_next;
    bpcq_pkg::qcnt_t      total_reg, total_next;
    bpcq_pkg::drop_t      drops_reg, drops_next;
    logic                 res_valid_reg, res_valid_next;
    bpcq_pkg::ebtn_t      res_button_reg, res_button_next;
    logic                 res_long_reg, res_long_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_event_reg, out_event_next;
    bpcq_pkg::ebtn_t      out_button_reg, out_button_next;
    logic                 out_long_reg, out_long_next;
    bpcq_pkg::drop_t      out_drops_reg, out_drops_next;
    bpcq_pkg::qout_t      out_count_reg, out_count_next;

    logic                 item_fire;
    logic                 cfg_fire;

    logic                 btn_we;
    logic [bpcq_pkg::ENTRY_W-1:0] btn_wdata, btn_rdata;
    logic                 ev_we;
    logic [bpcq_pkg::EVT_W-1:0] ev_wdata, ev_rdata;

    bpcq_pkg::bstate_t    cur_st, new_st;
    bpcq_pkg::time_t      cur_mark, new_mark, elapsed;
    logic                 push, push_long;

    assign item_fire = item.valid && item.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid         = out_valid_reg;
    assign result.event_valid   = out_event_reg;
    assign result.event_button  = out_button_reg;
    assign result.event_long    = out_long_reg;
    assign result.dropped_count = out_drops_reg;
    assign result.queue_count   = out_count_reg;

    // Button memory entry: tracking code above the mark time.
    bpcq_ram #(
        .WIDTH (bpcq_pkg::ENTRY_W),
        .DEPTH (bpcq_pkg::BUTTON_COUNT)
    ) u_btn_ram (
        .clk   (clk),
        .we    (btn_we),
        .waddr (proc_idx_reg),
        .wdata (btn_wdata),
        .raddr (scan_cnt_reg[bpcq_pkg::BTN_W-1:0]),
        .rdata (btn_rdata)
    );

    // Event memory entry: long flag above the button index.
    bpcq_ram #(
        .WIDTH (bpcq_pkg::EVT_W),
        .DEPTH (bpcq_pkg::QUEUE_DEPTH)
    ) u_ev_ram (
        .clk   (clk),
        .we    (ev_we),
        .waddr (wr_idx_reg),
        .wdata (ev_wdata),
        .raddr (rd_idx_reg),
        .rdata (ev_rdata)
    );

    // Per-button update on the entry that arrived from the button memory. An entry
    // never written since reset reads as released with mark time zero.
    always_comb
    begin
        cur_st    = init_reg[proc_idx_reg] ? btn_rdata[bpcq_pkg::ENTRY_W-1:bpcq_pkg::TIME_W]
                                           : bpcq_pkg::ST_RELEASED;
        cur_mark  = init_reg[proc_idx_reg] ? btn_rdata[bpcq_pkg::TIME_W-1:0] : '0;
        elapsed   = now_reg - cur_mark;
        new_st    = cur_st;
        new_mark  = cur_mark;
        push      = 1'b0;
        push_long = 1'b0;
        if (!levels_reg[proc_idx_reg])
        begin
            case (cur_st)
                bpcq_pkg::ST_RELEASED:
                begin
                    if (elapsed >= bpcq_pkg::time_t'(debounce_reg))
                    begin
                        new_st   = bpcq_pkg::ST_PRESSED;
                        new_mark = now_reg;
                    end
                end
                bpcq_pkg::ST_PRESSED:
                begin
                    if (elapsed >= bpcq_pkg::time_t'(long_hold_reg))
                    begin
                        push      = 1'b1;
                        push_long = 1'b1;
                        new_st    = bpcq_pkg::ST_WAITING;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            if (cur_st == bpcq_pkg::ST_PRESSED)
            begin
                push      = 1'b1;
                push_long = (elapsed > bpcq_pkg::time_t'(long_release_reg));
            end
            new_st   = bpcq_pkg::ST_RELEASED;
            new_mark = now_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        proc_valid_next = proc_valid_reg;
        proc_idx_next   = proc_idx_reg;
        levels_next     = levels_reg;
        now_next        = now_reg;
        init_next       = init_reg;
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        total_next      = total_reg;
        drops_next      = drops_reg;
        res_valid_next  = res_valid_reg;
        res_button_next = res_button_reg;
        res_long_next   = res_long_reg;
        out_valid_next  = out_valid_reg;
        out_event_next  = out_event_reg;
        out_button_next = out_button_reg;
        out_long_next   = out_long_reg;
        out_drops_next  = out_drops_reg;
        out_count_next  = out_count_reg;
        btn_we          = 1'b0;
        btn_wdata       = {new_st, new_mark};
        ev_we           = 1'b0;
        ev_wdata        = {push_long, bpcq_pkg::ebtn_t'(proc_idx_reg)};

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    levels_next     = item.button_levels;
                    now_next        = item.now_ms;
                    drops_next      = '0;
                    res_valid_next  = 1'b0;
                    res_button_next = '0;
                    res_long_next   = 1'b0;
                    if (item.func == bpcq_pkg::FUNC_POP)
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        state_next      = S_SCAN;
                        scan_cnt_next   = '0;
                        proc_valid_next = 1'b0;
                    end
                end
            end
            S_SCAN:
            begin
                // Reads run one button ahead of the update, so the write to one entry
                // never meets a read of the same entry.
                if (scan_cnt_reg < bpcq_pkg::BCNT_END)
                begin
                    proc_valid_next = 1'b1;
                    proc_idx_next   = scan_cnt_reg[bpcq_pkg::BTN_W-1:0];
                    scan_cnt_next   = scan_cnt_reg + 1'b1;
                end
                else
                begin
                    proc_valid_next = 1'b0;
                    state_next      = S_DONE;
                end
                if (proc_valid_reg)
                begin
                    btn_we                  = 1'b1;
                    init_next[proc_idx_reg] = 1'b1;
                    if (push)
                    begin
                        if (total_reg >= bpcq_pkg::QUEUE_FULL)
                        begin
                            if (drops_reg != bpcq_pkg::DROP_MAX)
                            begin
                                drops_next = drops_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            ev_we       = 1'b1;
                            wr_idx_next = (wr_idx_reg == bpcq_pkg::QIDX_LAST) ? '0
                                                                             : wr_idx_reg + 1'b1;
                            total_next  = total_reg + 1'b1;
                        end
                    end
                end
            end
            S_POP:
            begin
                if (total_reg != '0)
                begin
                    res_valid_next  = 1'b1;
                    res_button_next = ev_rdata[bpcq_pkg::EBTN_W-1:0];
                    res_long_next   = ev_rdata[bpcq_pkg::EVT_W-1];
                    rd_idx_next     = (rd_idx_reg == bpcq_pkg::QIDX_LAST) ? '0
                                                                         : rd_idx_reg + 1'b1;
                    total_next      = total_reg - 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_event_next  = res_valid_reg;
                    out_button_next = res_button_reg;
                    out_long_next   = res_long_reg;
                    out_drops_next  = drops_reg;
                    out_count_next  = bpcq_pkg::qout_t'(total_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            debounce_reg     <= bpcq_pkg::DEBOUNCE_RESET;
            long_hold_reg    <= bpcq_pkg::LONG_HOLD_RESET;
            long_release_reg <= bpcq_pkg::LONG_RELEASE_RESET;
            scan_cnt_reg     <= '0;
            proc_valid_reg   <= 1'b0;
            init_reg         <= '0;
            wr_idx_reg       <= '0;
            rd_idx_reg       <= '0;
            total_reg        <= '0;
            drops_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            proc_valid_reg <= proc_valid_next;
            init_reg       <= init_next;
            wr_idx_reg     <= wr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            total_reg      <= total_next;
            drops_reg      <= drops_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_fire)
            begin
                case (cfg.index)
                    bpcq_pkg::REG_DEBOUNCE:     debounce_reg     <= cfg.data;
                    bpcq_pkg::REG_LONG_HOLD:    long_hold_reg    <= cfg.data;
                    bpcq_pkg::REG_LONG_RELEASE: long_release_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg   <= proc_idx_next;
        levels_reg     <= levels_next;
        now_reg        <= now_next;
        res_valid_reg  <= res_valid_next;
        res_button_reg <= res_button_next;
        res_long_reg   <= res_long_next;
        out_event_reg  <= out_event_next;
        out_button_reg <= out_button_next;
        out_long_reg   <= out_long_next;
        out_drops_reg  <= out_drops_next;
        out_count_reg  <= out_count_next;
    end

    `BPCQ_ASSERT_SAME(a_total_bound, 1'b1, total_reg <= bpcq_pkg::QUEUE_FULL,
        "queue count above depth")
    `BPCQ_ASSERT_SAME(a_no_write_full, ev_we, total_reg < bpcq_pkg::QUEUE_FULL,
        "event written into full queue")
    `BPCQ_ASSERT_SAME(a_empty_ptrs, total_reg == '0, wr_idx_reg == rd_idx_reg,
        "empty queue with unequal pointers")
    `BPCQ_ASSERT_NEXT(a_busy_after_accept, item_fire, state_reg != S_IDLE,
        "accepted item left no work")
    `BPCQ_ASSERT_SAME(a_drop_on_scan_only, out_valid_reg && out_drops_reg != '0,
        !out_event_reg, "drops reported with a popped event")

endmodule

// ===== design/bpcq_ram.sv =====
`timescale 1ns / 1ps

module bpcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/button_press_classifier_queue_tb.sv =====
`timescale 1ns / 1ps

module button_press_classifier_queue_tb;

    localparam int SCAN_LATENCY  = 11;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_COUNT   = 9;
    localparam int PHASE_ITEMS   = 135;

    typedef logic [bpcq_pkg::LEVEL_W-1:0] level_t;

    typedef enum logic [1:0] {STIM_ITEM, STIM_CFG, STIM_DRAIN} stim_kind_t;

    typedef struct {
        stim_kind_t                       kind;
        logic                             func;
        level_t                           levels;
        bpcq_pkg::time_t                  now;
        logic [bpcq_pkg::CFG_IDX_W-1:0]   reg_index;
        bpcq_pkg::cfg_t                   reg_data;
    } stim_t;

    typedef struct {
        logic             ev_valid;
        bpcq_pkg::ebtn_t  ev_button;
        logic             ev_long;
        bpcq_pkg::drop_t  drops;
        bpcq_pkg::qout_t  qcount;
    } press_result_t;

    logic clk = 1'b0;
    logic rst_n;

    bpcq_item_if   item_ch();
    bpcq_result_if result_ch();
    bpcq_cfg_if    cfg_ch();

    button_press_classifier_queue u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    stim_t         pending_q[$];
    press_result_t expected_q[$];
    int            sent_cnt = 0;
    int            recv_cnt = 0;
    int            err_cnt  = 0;

    // Classifier state as the block should hold it.
    bpcq_pkg::bstate_t          btn_st[bpcq_pkg::BUTTON_COUNT];
    bpcq_pkg::time_t            btn_mark[bpcq_pkg::BUTTON_COUNT];
    logic [bpcq_pkg::EVT_W-1:0] event_ring[bpcq_pkg::QUEUE_DEPTH];
    bpcq_pkg::qidx_t            ring_wr;
    bpcq_pkg::qidx_t            ring_rd;
    int                         ring_held;
    bpcq_pkg::cfg_t             debounce_set;
    bpcq_pkg::cfg_t             long_hold_set;
    bpcq_pkg::cfg_t             long_release_set;

    // Sender and receiver pacing.
    int burst_left;
    int gap_left;
    int settle;
    int ready_mode;
    int mode_left;
    int stall_left;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic queue_event(input int b, input logic is_long, inout int drops);
        if (ring_held >= bpcq_pkg::QUEUE_DEPTH)
        begin
            if (drops < 15)
                drops++;
        end
        else
        begin
            event_ring[ring_wr] = {is_long, bpcq_pkg::ebtn_t'(b)};
            ring_wr++;
            ring_held++;
        end
    endtask

    task automatic classify_item(input logic f, input level_t lv, input bpcq_pkg::time_t now);
        press_result_t              r;
        bpcq_pkg::time_t            elapsed;
        int                         drops;
        logic [bpcq_pkg::EVT_W-1:0] ev;
        r = '{default: '0};
        drops = 0;
        if (f == bpcq_pkg::FUNC_SCAN)
        begin
            for (int b = 0; b < bpcq_pkg::BUTTON_COUNT; b++)
            begin
                elapsed = now - btn_mark[b];
                if (!lv[b])
                begin
                    if (btn_st[b] == bpcq_pkg::ST_RELEASED)
                    begin
                        if (elapsed >= bpcq_pkg::time_t'(debounce_set))
                        begin
                            btn_st[b]   = bpcq_pkg::ST_PRESSED;
                            btn_mark[b] = now;
                        end
                    end
                    else if (btn_st[b] == bpcq_pkg::ST_PRESSED)
                    begin
                        if (elapsed >= bpcq_pkg::time_t'(long_hold_set))
                        begin
                            queue_event(b, 1'b1, drops);
                            btn_st[b] = bpcq_pkg::ST_WAITING;
                        end
                    end
                end
                else
                begin
                    if (btn_st[b] == bpcq_pkg::ST_PRESSED)
                        queue_event(b, elapsed > bpcq_pkg::time_t'(long_release_set), drops);
                    btn_st[b]   = bpcq_pkg::ST_RELEASED;
                    btn_mark[b] = now;
                end
            end
        end
        else if (ring_held > 0)
        begin
            ev = event_ring[ring_rd];
            ring_rd++;
            ring_held--;
            r.ev_valid  = 1'b1;
            r.ev_button = ev[bpcq_pkg::EBTN_W-1:0];
            r.ev_long   = ev[bpcq_pkg::EVT_W-1];
        end
        r.drops  = bpcq_pkg::drop_t'(drops);
        r.qcount = bpcq_pkg::qout_t'(ring_held);
        expected_q.push_back(r);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    task automatic add_item(input logic f, input level_t lv, input bpcq_pkg::time_t now);
        stim_t s;
        s.kind      = STIM_ITEM;
        s.func      = f;
        s.levels    = lv;
        s.now       = now;
        s.reg_index = '0;
        s.reg_data  = '0;
        pending_q.push_back(s);
    endtask

    task automatic add_cfg(input logic [bpcq_pkg::CFG_IDX_W-1:0] idx,
                           input bpcq_pkg::cfg_t data);
        stim_t s;
        s.kind      = STIM_CFG;
        s.func      = bpcq_pkg::FUNC_SCAN;
        s.levels    = '0;
        s.now       = '0;
        s.reg_index = idx;
        s.reg_data  = data;
        pending_q.push_back(s);
    endtask

    task automatic add_drain();
        stim_t s;
        s.kind      = STIM_DRAIN;
        s.func      = bpcq_pkg::FUNC_SCAN;
        s.levels    = '0;
        s.now       = '0;
        s.reg_index = '0;
        s.reg_data  = '0;
        pending_q.push_back(s);
    endtask

    // Driver: feeds items and register writes from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        logic  nxt_item_valid;
        logic  nxt_cfg_valid;
        stim_t head;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            cfg_ch.valid  <= 1'b0;
            for (int b = 0; b < bpcq_pkg::BUTTON_COUNT; b++)
            begin
                btn_st[b]   = bpcq_pkg::ST_RELEASED;
                btn_mark[b] = '0;
            end
            ring_wr          = '0;
            ring_rd          = '0;
            ring_held        = 0;
            debounce_set     = bpcq_pkg::DEBOUNCE_RESET;
            long_hold_set    = bpcq_pkg::LONG_HOLD_RESET;
            long_release_set = bpcq_pkg::LONG_RELEASE_RESET;
            burst_left       = $urandom_range(1, 40);
            gap_left         = 0;
            settle           = 0;
        end
        else
        begin
            nxt_item_valid = item_ch.valid;
            nxt_cfg_valid  = cfg_ch.valid;
            if (item_ch.valid && item_ch.ready)
            begin
                classify_item(item_ch.func, item_ch.button_levels, item_ch.now_ms);
                sent_cnt++;
                nxt_item_valid = 1'b0;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    bpcq_pkg::REG_DEBOUNCE:     debounce_set     = cfg_ch.data;
                    bpcq_pkg::REG_LONG_HOLD:    long_hold_set    = cfg_ch.data;
                    bpcq_pkg::REG_LONG_RELEASE: long_release_set = cfg_ch.data;
                    default: ;
                endcase
                void'(pending_q.pop_front());
                nxt_cfg_valid = 1'b0;
            end
            if (!nxt_item_valid && !nxt_cfg_valid && pending_q.size() > 0)
            begin
                head = pending_q[0];
                if (head.kind == STIM_ITEM)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    else
                    begin
                        item_ch.func          <= head.func;
                        item_ch.button_levels <= head.levels;
                        item_ch.now_ms        <= head.now;
                        nxt_item_valid = 1'b1;
                        void'(pending_q.pop_front());
                        burst_left--;
                        if (burst_left <= 0)
                        begin
                            burst_left = $urandom_range(1, 40);
                            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                        end
                    end
                end
                else
                begin
                    // Register writes and drain points wait for the block to go idle.
                    if (sent_cnt != recv_cnt)
                        settle = 0;
                    else if (settle < SETTLE_CYCLES)
                        settle++;
                    else
                    begin
                        settle = 0;
                        if (head.kind == STIM_CFG)
                        begin
                            cfg_ch.index <= head.reg_index;
                            cfg_ch.data  <= head.reg_data;
                            nxt_cfg_valid = 1'b1;
                        end
                        else
                            void'(pending_q.pop_front());
                    end
                end
            end
            item_ch.valid <= nxt_item_valid;
            cfg_ch.valid  <= nxt_cfg_valid;
        end
    end

    // Monitor: checks each result transaction and paces the ready line.
    always @(posedge clk or negedge rst_n)
    begin
        press_result_t want;
        logic          nxt_ready;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_cnt        <= 0;
            ready_mode       = 0;
            mode_left        = 0;
            stall_left       = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transaction with no expected result pending");
                    err_cnt++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("event_valid", 32'(want.ev_valid),
                                32'(result_ch.event_valid));
                    check_field("event_button", 32'(want.ev_button),
                                32'(result_ch.event_button));
                    check_field("event_long", 32'(want.ev_long),
                                32'(result_ch.event_long));
                    check_field("dropped_count", 32'(want.drops),
                                32'(result_ch.dropped_count));
                    check_field("queue_count", 32'(want.qcount),
                                32'(result_ch.queue_count));
                end
                recv_cnt <= recv_cnt + 1;
            end
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(50, 300);
            end
            else
                mode_left--;
            case (ready_mode)
                0: nxt_ready = 1'b1;
                1: nxt_ready = 1'($urandom_range(0, 1));
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        nxt_ready = 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left = $urandom_range(5, 40);
                        nxt_ready  = 1'b0;
                    end
                    else
                        nxt_ready = 1'b1;
                end
            endcase
            result_ch.ready <= nxt_ready;
        end
    end

    initial
    begin
        bpcq_pkg::time_t   clock_ms;
        level_t            pins;
        bpcq_pkg::time_t   step;
        int                kind;
        int                pop_pct;
        bpcq_pkg::cfg_t    d_val;
        bpcq_pkg::cfg_t    h_val;
        bpcq_pkg::cfg_t    r_val;
        int                pop_table[PHASE_COUNT];

        item_ch.valid         = 1'b0;
        item_ch.func          = bpcq_pkg::FUNC_SCAN;
        item_ch.button_levels = '1;
        item_ch.now_ms        = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = bpcq_pkg::REG_DEBOUNCE;
        cfg_ch.data           = '0;
        result_ch.ready       = 1'b0;
        rst_n                 = 1'b0;

        // Directed part under the reset thresholds of 20, 1300 and 1000 ms.
        add_item(bpcq_pkg::FUNC_POP,  8'h00, 32'd0);            // pop on an empty queue
        add_item(bpcq_pkg::FUNC_SCAN, 8'hFF, 32'd0);
        add_item(bpcq_pkg::FUNC_SCAN, 8'h00, 32'd19);     // one short of the debounce time
        add_item(bpcq_pkg::FUNC_SCAN, 8'h00, 32'd20);     // press accepted on every button
        add_item(bpcq_pkg::FUNC_SCAN, 8'h00, 32'd1319);
        add_item(bpcq_pkg::FUNC_SCAN, 8'h00, 32'd1320);   // long hold fires on all eight
        add_item(bpcq_pkg::FUNC_SCAN, 8'h00, 32'd5000);   // waiting for release, no change
        add_item(bpcq_pkg::FUNC_POP,  8'hFF, 32'hFFFF_FFFF);
        add_item(bpcq_pkg::FUNC_SCAN, 8'hFF, 32'd5001);   // release from waiting is silent
        add_item(bpcq_pkg::FUNC_SCAN, 8'h00, 32'd5021);
        add_item(bpcq_pkg::FUNC_SCAN, 8'h0F, 32'd6021);   // exactly the release threshold
        add_item(bpcq_pkg::FUNC_SCAN, 8'hFF, 32'd6022);   // one past it: long
        for (int i = 0; i < 5; i++)
            add_item(bpcq_pkg::FUNC_POP, 8'h00, 32'd0);
        add_item(bpcq_pkg::FUNC_SCAN, 8'hFF, 32'hFFFF_FFF0);
        add_item(bpcq_pkg::FUNC_SCAN, 8'h00, 32'h0000_0004);    // elapsed time across the wrap
        add_item(bpcq_pkg::FUNC_SCAN, 8'hAA, 32'h0000_0005);
        add_item(bpcq_pkg::FUNC_SCAN, 8'h55, 32'hFFFF_FFFF);
        add_item(bpcq_pkg::FUNC_POP,  8'h5A, 32'h8000_0000);

        pop_table = '{30, 0, 3, 85, 30, 40, 0, 80, 50};
        clock_ms  = 32'd16;
        pins      = '1;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            add_drain();
            case (phase)
                0:
                begin
                    d_val = bpcq_pkg::DEBOUNCE_RESET;
                    h_val = bpcq_pkg::LONG_HOLD_RESET;
                    r_val = bpcq_pkg::LONG_RELEASE_RESET;
                end
                1, 6:
                begin
                    d_val = '0;
                    h_val = '0;
                    r_val = '0;
                end
                4:
                begin
                    d_val = '1;
                    h_val = '1;
                    r_val = '1;
                end
                5:
                begin
                    d_val = bpcq_pkg::cfg_t'($urandom);
                    h_val = bpcq_pkg::cfg_t'($urandom);
                    r_val = bpcq_pkg::cfg_t'($urandom);
                end
                8:
                begin
                    d_val = '0;
                    h_val = '1;
                    r_val = '0;
                end
                default:
                begin
                    d_val = bpcq_pkg::cfg_t'($urandom_range(0, 10));
                    h_val = bpcq_pkg::cfg_t'($urandom_range(0, 40));
                    r_val = bpcq_pkg::cfg_t'($urandom_range(0, 40));
                end
            endcase
            add_cfg(bpcq_pkg::REG_DEBOUNCE, d_val);
            add_cfg(bpcq_pkg::REG_LONG_HOLD, h_val);
            add_cfg(bpcq_pkg::REG_LONG_RELEASE, r_val);
            pop_pct = pop_table[phase];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < 8)
                    add_item(1'($urandom_range(0, 1)), level_t'($urandom), $urandom);
                else if ($urandom_range(0, 99) < pop_pct)
                    add_item(bpcq_pkg::FUNC_POP, level_t'($urandom), $urandom);
                else
                begin
                    // Pins mostly hold their level so that presses can mature.
                    if ($urandom_range(0, 4) != 0)
                        pins = pins ^ level_t'($urandom & $urandom);
                    kind = $urandom_range(0, 19);
                    if (kind < 10)
                        step = $urandom_range(1, 25);
                    else if (kind < 16)
                        step = $urandom_range(0, 1500);
                    else if (kind < 19)
                        step = $urandom_range(0, 70000);
                    else
                        step = $urandom;
                    clock_ms = clock_ms + step;
                    add_item(bpcq_pkg::FUNC_SCAN, pins, clock_ms);
                end
                if (i == PHASE_ITEMS / 2)
                    add_drain();
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (!(pending_q.size() == 0 && !item_ch.valid && !cfg_ch.valid
                 && sent_cnt == recv_cnt));
        repeat (4 * SCAN_LATENCY) @(negedge clk);

        if (expected_q.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("button_press_classifier_queue_tb: clean");
        else
            $display("button_press_classifier_queue_tb: errors");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("button_press_classifier_queue_tb: errors");
        $finish;
    end

endmodule
